FILE: design/nrc_pkg.sv
// Package for the normalized RGB convolution unit.
// Holds shared widths, default parameter values and register indexes.
// No dependencies.
package nrc_pkg;

	localparam int MAX_KERNEL_DEF = 7;
	localparam int MAX_COLS_DEF   = 1024;
	localparam int COEF_BITS_DEF  = 16;
	localparam int MAX_ROWS       = 1024;

	localparam int PIX_W    = 8;
	localparam int POS_W    = 10;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd2;

	localparam logic REQ_COEF  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

endpackage

FILE: design/nrc_div.sv
// Three-lane restoring divider, one quotient bit per lane each cycle.
// Returns the low byte of each quotient. Depends on nrc_pkg.
module nrc_div #(
	parameter int ACC_W = 30,
	parameter int SUM_W = 22
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [2:0][ACC_W-1:0]               dividend,
	input  logic [SUM_W-1:0]                    divisor,
	output logic                                done,
	output logic [2:0][nrc_pkg::PIX_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [2:0][ACC_W-1:0] dvd_q;
	logic [2:0][SUM_W-1:0] rem_q;
	logic [SUM_W-1:0]      dsr_q;
	logic [2:0][SUM_W:0]   trial;
	logic [2:0]            fits;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], dvd_q[i][ACC_W-1]};
			fits[i]  = trial[i] >= {1'b0, dsr_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				if (fits[i]) begin
					rem_q[i] <= SUM_W'(trial[i] - {1'b0, dsr_q});
				end else begin
					rem_q[i] <= trial[i][SUM_W-1:0];
				end
				dvd_q[i] <= {dvd_q[i][ACC_W-2:0], fits[i]};
			end
		end
	end

	assign done = done_q;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quotient[i] = dvd_q[i][nrc_pkg::PIX_W-1:0];
		end
	end

endmodule

FILE: design/normalized_rgb_convolution_unit.sv
// Top level of the normalized RGB convolution unit. Depends on nrc_pkg and nrc_div.
// Holds the coefficient table, the line store and the multiply-accumulate sequencer.
//
// A pixel word that completes a kernel window runs one multiply-accumulate per kernel tap
// on the shared three-channel MAC, waits for the MAC pipeline to drain, then runs a
// serial divide of one quotient bit per cycle over the 30-bit sums, which is skipped
// when the kernel sum is zero. A pixel word without a full window is only written to
// the line store. A coefficient word for an entry inside the table, and a write of the
// kernel side register, start a pass that recomputes the kernel sum; s_axis_tready
// stays low during that pass. The finished output word sits in an output register,
// so the next input word is taken while it waits.
module normalized_rgb_convolution_unit #(
	parameter int MAX_KERNEL = nrc_pkg::MAX_KERNEL_DEF,
	parameter int MAX_COLS   = nrc_pkg::MAX_COLS_DEF,
	parameter int COEF_BITS  = nrc_pkg::COEF_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [nrc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nrc_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// coef_index, coef_value, red_in, green_in, blue_in, zero fill
	input  logic [nrc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// req_type
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// red_out, green_out, blue_out, out_row, out_col, zero fill
	output logic [nrc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tlast,
	// norm_zero
	output logic                               m_axis_tuser
);

	localparam int TABLE_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int TA_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int KK_W  = $clog2(TABLE_DEPTH + 1);
	localparam int KW    = $clog2(MAX_KERNEL + 1);
	localparam int SUM_W = COEF_BITS + $clog2(TABLE_DEPTH + 1);
	localparam int ACC_W = nrc_pkg::PIX_W + SUM_W;
	localparam int PRD_W = nrc_pkg::PIX_W + COEF_BITS;
	localparam int LINES = MAX_KERNEL * MAX_COLS;
	localparam int LA_W  = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int CW1   = $clog2(MAX_COLS + 1);
	localparam int ROW_W = $clog2(nrc_pkg::MAX_ROWS);
	localparam int RW1   = $clog2(nrc_pkg::MAX_ROWS + 1);
	localparam int PX3_W = 3 * nrc_pkg::PIX_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SUM  = 4'd1;
	localparam logic [3:0] S_SUMD = 4'd2;
	localparam logic [3:0] S_POS  = 4'd3;
	localparam logic [3:0] S_WR   = 4'd4;
	localparam logic [3:0] S_MAC  = 4'd5;
	localparam logic [3:0] S_MACD = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;
	localparam logic [3:0] S_ADV  = 4'd9;

	logic [3:0] state_q;

	logic [2:0]                 ks_q;
	logic [nrc_pkg::CFG_W-1:0]  rl_q;
	logic [nrc_pkg::CFG_W-1:0]  rc_q;
	logic                       sum_pend_q;

	logic [KW-1:0]   k_eff;
	logic [KK_W-1:0] kk;
	logic [CW1-1:0]  cols;
	logic [RW1-1:0]  rows;

	always_comb begin
		if (ks_q == 3'd0) begin
			k_eff = KW'(1);
		end else if (32'(ks_q) > MAX_KERNEL) begin
			k_eff = KW'(MAX_KERNEL);
		end else begin
			k_eff = KW'(ks_q);
		end
		kk = KK_W'(k_eff) * KK_W'(k_eff);
		if (rl_q == '0) begin
			cols = CW1'(1);
		end else if (32'(rl_q) > MAX_COLS) begin
			cols = CW1'(MAX_COLS);
		end else begin
			cols = CW1'(rl_q);
		end
		if (rc_q == '0) begin
			rows = RW1'(1);
		end else if (32'(rc_q) > nrc_pkg::MAX_ROWS) begin
			rows = RW1'(nrc_pkg::MAX_ROWS);
		end else begin
			rows = RW1'(rc_q);
		end
	end

	logic in_acc;
	logic [5:0]            in_idx;
	logic [15:0]           in_coef;
	logic [PX3_W-1:0]      in_pix;

	assign in_idx  = s_axis_tdata[5:0];
	assign in_coef = s_axis_tdata[21:6];
	assign in_pix  = s_axis_tdata[45:22];
	assign s_axis_tready = (state_q == S_IDLE) && !sum_pend_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// Coefficient table with per-entry valid bits standing in for the zero reset.
	logic [COEF_BITS-1:0]   coef_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] coef_vld_q;
	logic                   coef_we;
	logic [TA_W-1:0]        coef_wa;
	logic [TA_W-1:0]        coef_ra;
	logic [COEF_BITS-1:0]   coef_rd_s1;
	logic                   coef_rv_s1;
	logic [COEF_BITS-1:0]   coef_val_s1;

	assign coef_we = in_acc && (s_axis_tuser == nrc_pkg::REQ_COEF) && (32'(in_idx) < TABLE_DEPTH);
	assign coef_wa = TA_W'(in_idx);

	logic [KK_W-1:0] si_q;
	logic [TA_W-1:0] ca_q;
	assign coef_ra = (state_q == S_SUM) ? TA_W'(si_q) : ca_q;

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wa] <= COEF_BITS'(in_coef);
		end
		coef_rd_s1 <= coef_mem[coef_ra];
		coef_rv_s1 <= coef_vld_q[coef_ra];
	end
	assign coef_val_s1 = coef_rv_s1 ? coef_rd_s1 : '0;

	// Line store, one row of pixels per slot.
	logic [PX3_W-1:0] line_mem [LINES];
	logic [LA_W-1:0]  la_q;
	logic [PX3_W-1:0] line_rd_s1;
	logic [LA_W-1:0]  base_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PX3_W-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (state_q == S_WR) begin
			line_mem[LA_W'(base_q + LA_W'(col_q))] <= pix_q;
		end
		line_rd_s1 <= line_mem[la_q];
	end

	// Position stepping shared by the wrap check and the advance.
	logic [CW1:0]    col_t;
	logic [RW1:0]    row_t;
	logic [LA_W:0]   base_t;
	logic [COL_W-1:0] col_n;
	logic [ROW_W-1:0] row_n;
	logic [LA_W-1:0]  base_n;

	always_comb begin
		col_t  = (CW1+1)'(col_q) + ((state_q == S_ADV) ? (CW1+1)'(1) : '0);
		row_t  = (RW1+1)'(row_q);
		base_t = (LA_W+1)'(base_q);
		if (col_t >= (CW1+1)'(cols)) begin
			col_t  = '0;
			row_t  = row_t + 1'b1;
			base_t = base_t + (LA_W+1)'(MAX_COLS);
			if (base_t >= (LA_W+1)'(LINES)) begin
				base_t = '0;
			end
		end
		if (row_t >= (RW1+1)'(rows)) begin
			row_t  = '0;
			base_t = '0;
		end
		col_n  = COL_W'(col_t);
		row_n  = ROW_W'(row_t);
		base_n = LA_W'(base_t);
	end

	// Window geometry for the newest pixel.
	logic              win_ok;
	logic [LA_W:0]     off;
	logic [LA_W-1:0]   top_base;
	logic [COL_W-1:0]  left;
	logic [ROW_W-1:0]  top;

	always_comb begin
		win_ok = ((RW1+1)'(row_q) + 1'b1 >= (RW1+1)'(k_eff))
			&& ((CW1+1)'(col_q) + 1'b1 >= (CW1+1)'(k_eff));
		off = (LA_W+1)'((k_eff - 1'b1) * MAX_COLS);
		if ((LA_W+1)'(base_q) >= off) begin
			top_base = LA_W'((LA_W+1)'(base_q) - off);
		end else begin
			top_base = LA_W'((LA_W+1)'(base_q) + (LA_W+1)'(LINES) - off);
		end
		left = COL_W'(col_q - COL_W'(k_eff - 1'b1));
		top  = ROW_W'(row_q - ROW_W'(k_eff - 1'b1));
	end

	logic [KW-1:0]   kr_q;
	logic [KW-1:0]   kc_q;
	logic [LA_W-1:0] rb_q;
	logic [COL_W-1:0] left_q;
	logic [LA_W:0]   rb_next;
	logic            iss;
	logic            iss_s1;
	logic            prv_s2;
	logic            sm;
	logic            sm_s1;
	logic [SUM_W-1:0] sum_q;
	logic [2:0][PRD_W-1:0] prod_s2;
	logic [2:0][ACC_W-1:0] acc_q;

	always_comb begin
		rb_next = (LA_W+1)'(rb_q) + (LA_W+1)'(MAX_COLS);
		if (rb_next >= (LA_W+1)'(LINES)) begin
			rb_next = '0;
		end
	end

	assign iss = (state_q == S_MAC);
	assign sm  = (state_q == S_SUM) && (si_q < kk);

	logic                            div_start;
	logic                            div_done;
	logic [2:0][nrc_pkg::PIX_W-1:0]  div_q;

	nrc_div #(
		.ACC_W (ACC_W),
		.SUM_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign div_start = (state_q == S_MACD) && !iss_s1 && !prv_s2 && (sum_q != '0);

	logic [ROW_W-1:0] res_row_q;
	logic [COL_W-1:0] res_col_q;
	logic             res_last_q;
	logic [2:0][nrc_pkg::PIX_W-1:0] out_pix_q;
	logic [nrc_pkg::POS_W-1:0] out_row_q;
	logic [nrc_pkg::POS_W-1:0] out_col_q;
	logic             out_last_q;
	logic             out_nz_q;
	logic             m_valid_q;
	logic             res_nz_q;
	logic [2:0][nrc_pkg::PIX_W-1:0] res_pix_q;
	logic             out_load;

	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ks_q       <= 3'd3;
			rl_q       <= nrc_pkg::CFG_W'(1024);
			rc_q       <= nrc_pkg::CFG_W'(1024);
			sum_pend_q <= 1'b0;
			coef_vld_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			base_q     <= '0;
			sum_q      <= '0;
			iss_s1     <= 1'b0;
			prv_s2     <= 1'b0;
			sm_s1      <= 1'b0;
			m_valid_q  <= 1'b0;
			si_q       <= '0;
		end else begin
			iss_s1 <= iss;
			prv_s2 <= iss_s1;
			sm_s1  <= sm;
			if (sm_s1) begin
				sum_q <= sum_q + SUM_W'(coef_val_s1);
			end
			if (coef_we) begin
				coef_vld_q[coef_wa] <= 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if ((cfg_we && cfg_index == nrc_pkg::CFG_KERNEL_SIDE) || coef_we) begin
				sum_pend_q <= 1'b1;
			end else if (state_q == S_IDLE) begin
				sum_pend_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					nrc_pkg::CFG_KERNEL_SIDE: ks_q <= cfg_data[2:0];
					nrc_pkg::CFG_ROW_LENGTH:  rl_q <= cfg_data;
					nrc_pkg::CFG_ROW_COUNT:   rc_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (sum_pend_q) begin
						si_q    <= '0;
						sum_q   <= '0;
						state_q <= S_SUM;
					end else if (in_acc && s_axis_tuser == nrc_pkg::REQ_PIXEL) begin
						state_q <= S_POS;
					end
				end
				S_SUM: begin
					if (si_q < kk) begin
						si_q <= si_q + 1'b1;
					end else begin
						state_q <= S_SUMD;
					end
				end
				S_SUMD: begin
					if (!sm_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_POS: begin
					col_q   <= col_n;
					row_q   <= row_n;
					base_q  <= base_n;
					state_q <= S_WR;
				end
				S_WR: begin
					state_q <= win_ok ? S_MAC : S_ADV;
				end
				S_MAC: begin
					if (kc_q == k_eff - 1'b1 && kr_q == k_eff - 1'b1) begin
						state_q <= S_MACD;
					end
				end
				S_MACD: begin
					if (!iss_s1 && !prv_s2) begin
						state_q <= (sum_q == '0) ? S_OUT : S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					col_q   <= col_n;
					row_q   <= row_n;
					base_q  <= base_n;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q <= in_pix;
		end
		if (state_q == S_WR) begin
			kr_q       <= '0;
			kc_q       <= '0;
			ca_q       <= '0;
			rb_q       <= top_base;
			la_q       <= LA_W'(top_base + LA_W'(left));
			left_q     <= left;
			acc_q      <= '0;
			res_row_q  <= top;
			res_col_q  <= left;
			res_last_q <= ((RW1+1)'(row_q) + 1'b1 == (RW1+1)'(rows))
				&& ((CW1+1)'(col_q) + 1'b1 == (CW1+1)'(cols));
		end
		if (iss) begin
			ca_q <= ca_q + 1'b1;
			if (kc_q == k_eff - 1'b1) begin
				kc_q <= '0;
				kr_q <= kr_q + 1'b1;
				rb_q <= LA_W'(rb_next);
				la_q <= LA_W'(LA_W'(rb_next) + LA_W'(left_q));
			end else begin
				kc_q <= kc_q + 1'b1;
				la_q <= la_q + 1'b1;
			end
		end
		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= PRD_W'(line_rd_s1[i*nrc_pkg::PIX_W +: nrc_pkg::PIX_W])
				* PRD_W'(coef_val_s1);
			if (prv_s2) begin
				acc_q[i] <= acc_q[i] + ACC_W'(prod_s2[i]);
			end
		end
		if (state_q == S_MACD && !iss_s1 && !prv_s2) begin
			res_nz_q  <= (sum_q == '0);
			res_pix_q <= '0;
		end
		if (div_done) begin
			res_pix_q <= div_q;
		end
		if (out_load) begin
			out_pix_q  <= res_pix_q;
			out_row_q  <= nrc_pkg::POS_W'(res_row_q);
			out_col_q  <= nrc_pkg::POS_W'(res_col_q);
			out_last_q <= res_last_q;
			out_nz_q   <= res_nz_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, out_col_q, out_row_q, out_pix_q[2], out_pix_q[1], out_pix_q[0]};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_nz_q;

`ifndef SYNTHESIS
	a_busy_after_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser == nrc_pkg::REQ_PIXEL) |=> !s_axis_tready)
		else $error("ready high right after a pixel word");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == S_OUT)
		else $error("output word raised outside the output step");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide step");
`endif

endmodule

FILE: tb/normalized_rgb_convolution_unit_tb.sv
// Self-checking testbench for normalized_rgb_convolution_unit: directed table, then random frames.
// Each output word is checked against an in-bench convolution predictor, or against the word given in a directed row.
// Depends on nrc_pkg and the RTL of the unit.
module normalized_rgb_convolution_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KMAX = 7;
	localparam int COLS_MAX = 1024;
	localparam int SETTLE = 120;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [9:0] row;
		logic [9:0] col;
		logic       last;
		logic       nz;
	} pix_out_t;

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		logic [nrc_pkg::CFG_IDX_W-1:0]     reg_idx;
		logic [nrc_pkg::CFG_W-1:0]         reg_val;
		logic                              req;
		logic [5:0]                        cidx;
		logic [15:0]                       cval;
		logic [7:0]                        r, g, b;
		bit                                typed;
		pix_out_t                          want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [nrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [nrc_pkg::CFG_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [nrc_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [nrc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;

	normalized_rgb_convolution_unit uut (.*);

	// Predictor state.
	logic [15:0] coef_mem [KMAX*KMAX];
	logic [23:0] line_mem [KMAX*COLS_MAX];
	longint unsigned coef_total;
	int unsigned pos_row, pos_col;
	logic [2:0] ksize_reg;
	logic [10:0] len_reg, cnt_reg;

	pix_out_t expected_pixels[$];
	stim_row_t stim_table[$];
	int errors = 0;
	int stall_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned eff_k();
		return (ksize_reg < 1) ? 1 : 32'(ksize_reg);
	endfunction

	function automatic int unsigned eff_cols();
		return (len_reg < 1) ? 1 : (len_reg > COLS_MAX) ? COLS_MAX : 32'(len_reg);
	endfunction

	function automatic int unsigned eff_rows();
		return (cnt_reg < 1) ? 1 : (cnt_reg > 1024) ? 1024 : 32'(cnt_reg);
	endfunction

	function automatic void refresh_total();
		int unsigned n;
		n = eff_k() * eff_k();
		coef_total = 0;
		for (int i = 0; i < n; i++) coef_total += 64'(coef_mem[i]);
	endfunction

	function automatic void predict_pixel(input logic [7:0] r, g, b, output bit emit,
			output pix_out_t o);
		int unsigned k, cols, rows, top, left, slot;
		longint unsigned acc_r, acc_g, acc_b, w;
		logic [23:0] px;
		k = eff_k();
		cols = eff_cols();
		rows = eff_rows();
		acc_r = 0;
		acc_g = 0;
		acc_b = 0;
		emit = 0;
		o = '0;
		if (pos_col >= cols) begin
			pos_col = 0;
			pos_row++;
		end
		if (pos_row >= rows) pos_row = 0;
		line_mem[(pos_row % KMAX) * COLS_MAX + pos_col] = {b, g, r};
		if (pos_row + 1 >= k && pos_col + 1 >= k) begin
			top = pos_row + 1 - k;
			left = pos_col + 1 - k;
			for (int kr = 0; kr < k; kr++) begin
				slot = ((top + kr) % KMAX) * COLS_MAX;
				for (int kc = 0; kc < k; kc++) begin
					px = line_mem[slot + left + kc];
					w = 64'(coef_mem[kr * k + kc]);
					acc_r += 64'(px[7:0]) * w;
					acc_g += 64'(px[15:8]) * w;
					acc_b += 64'(px[23:16]) * w;
				end
			end
			if (coef_total == 0) begin
				o.nz = 1'b1;
			end else begin
				o.red = 8'(acc_r / coef_total);
				o.green = 8'(acc_g / coef_total);
				o.blue = 8'(acc_b / coef_total);
			end
			o.row = 10'(top);
			o.col = 10'(left);
			o.last = (pos_row + 1 == rows && pos_col + 1 == cols);
			emit = 1;
		end
		pos_col++;
		if (pos_col >= cols) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= rows) pos_row = 0;
		end
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
	endtask

	// Waits until every expected word is out and the block has had time to settle.
	task automatic wait_quiet();
		while (expected_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [nrc_pkg::CFG_IDX_W-1:0] idx, logic [nrc_pkg::CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			nrc_pkg::CFG_KERNEL_SIDE: begin
				ksize_reg = val[2:0];
				refresh_total();
			end
			nrc_pkg::CFG_ROW_LENGTH: len_reg = val;
			nrc_pkg::CFG_ROW_COUNT: cnt_reg = val;
			default: ;
		endcase
		repeat (SETTLE) @(negedge clk);
	endtask

	// Sends one word and updates the predictor when it is accepted.
	task automatic send_word(logic req, logic [5:0] cidx, logic [15:0] cval,
			logic [7:0] r, g, b, bit typed, pix_out_t want);
		bit emit;
		pix_out_t o;
		while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = req;
		s_axis_tdata = {2'b00, b, g, r, cval, cidx};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (req == nrc_pkg::REQ_COEF) begin
			if (cidx < KMAX * KMAX) begin
				coef_mem[cidx] = cval;
				refresh_total();
			end
		end else begin
			predict_pixel(r, g, b, emit, o);
			if (emit) expected_pixels.push_back(typed ? want : o);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic send_pixel();
		send_word(nrc_pkg::REQ_PIXEL, 6'($urandom), 16'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 0, '0);
	endtask

	task automatic send_coef(logic [5:0] cidx, logic [15:0] cval);
		send_word(nrc_pkg::REQ_COEF, cidx, cval, 8'($urandom), 8'($urandom), 8'($urandom),
			0, '0);
	endtask

	function automatic logic [nrc_pkg::CFG_W-1:0] pick_extent(int unsigned hi);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) return 11'd0;
		if (roll < 5) return 11'd2047;
		if (roll < 7) return 11'd1024;
		return nrc_pkg::CFG_W'($urandom_range(1, hi));
	endfunction

	function automatic void add_cfg(logic [nrc_pkg::CFG_IDX_W-1:0] idx,
			logic [nrc_pkg::CFG_W-1:0] val);
		stim_row_t s;
		s.kind = ROW_CFG;
		s.reg_idx = idx;
		s.reg_val = val;
		s.typed = 0;
		stim_table.push_back(s);
	endfunction

	function automatic void add_word(logic req, logic [5:0] ci, logic [15:0] cv,
			logic [7:0] r, g, b, bit typed, pix_out_t want);
		stim_row_t s;
		s.kind = ROW_WORD;
		s.reg_idx = '0;
		s.reg_val = '0;
		s.req = req;
		s.cidx = ci;
		s.cval = cv;
		s.r = r;
		s.g = g;
		s.b = b;
		s.typed = typed;
		s.want = want;
		stim_table.push_back(s);
	endfunction

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		pix_out_t got, want;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else if (arst_n)
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("normalized_rgb_convolution_unit test failed");
			$finish;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
				m_axis_tdata[33:24], m_axis_tdata[43:34], m_axis_tlast, m_axis_tuser};
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = expected_pixels.pop_front();
				if (got.red !== want.red) report_mismatch("red_out", got.red, want.red);
				if (got.green !== want.green)
					report_mismatch("green_out", got.green, want.green);
				if (got.blue !== want.blue) report_mismatch("blue_out", got.blue, want.blue);
				if (got.row !== want.row) report_mismatch("out_row", got.row, want.row);
				if (got.col !== want.col) report_mismatch("out_col", got.col, want.col);
				if (got.last !== want.last) report_mismatch("last_pixel", got.last, want.last);
				if (got.nz !== want.nz) report_mismatch("norm_zero", got.nz, want.nz);
			end
		end
	end

	initial begin
		int unsigned k, npix, mode;
		logic [nrc_pkg::CFG_W-1:0] cols, rows;
		for (int i = 0; i < KMAX * KMAX; i++) coef_mem[i] = '0;
		for (int i = 0; i < KMAX * COLS_MAX; i++) line_mem[i] = '0;
		coef_total = 0;
		pos_row = 0;
		pos_col = 0;
		ksize_reg = 3'd3;
		len_reg = 11'd1024;
		cnt_reg = 11'd1024;

		// 2x2 image with a 1x1 kernel: zero sum first, then unit weight at full scale.
		add_cfg(nrc_pkg::CFG_KERNEL_SIDE, 11'd1);
		add_cfg(nrc_pkg::CFG_ROW_LENGTH, 11'd2);
		add_cfg(nrc_pkg::CFG_ROW_COUNT, 11'd2);
		add_word(nrc_pkg::REQ_PIXEL, 6'd63, 16'hFFFF, 8'd255, 8'd0, 8'd255, 1,
			'{8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b0, 1'b1});
		add_word(nrc_pkg::REQ_COEF, 6'd0, 16'hFFFF, 8'd255, 8'd255, 8'd255, 0, '0);
		add_word(nrc_pkg::REQ_PIXEL, 6'd0, 16'd0, 8'd255, 8'd255, 8'd255, 1,
			'{8'd255, 8'd255, 8'd255, 10'd0, 10'd1, 1'b0, 1'b0});
		add_word(nrc_pkg::REQ_PIXEL, 6'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1,
			'{8'd0, 8'd0, 8'd0, 10'd1, 10'd0, 1'b0, 1'b0});
		add_word(nrc_pkg::REQ_PIXEL, 6'd5, 16'd9, 8'd255, 8'd128, 8'd1, 1,
			'{8'd255, 8'd128, 8'd1, 10'd1, 10'd1, 1'b1, 1'b0});
		// Out-of-table index is dropped; entry 48 is stored but inactive.
		add_word(nrc_pkg::REQ_COEF, 6'd63, 16'd123, 8'd0, 8'd0, 8'd0, 0, '0);
		add_word(nrc_pkg::REQ_COEF, 6'd48, 16'hFFFF, 8'd0, 8'd0, 8'd0, 0, '0);
		add_word(nrc_pkg::REQ_PIXEL, 6'd0, 16'd0, 8'd7, 8'd8, 8'd9, 1,
			'{8'd7, 8'd8, 8'd9, 10'd0, 10'd0, 1'b0, 1'b0});
		add_cfg(nrc_pkg::CFG_KERNEL_SIDE, 11'd0);
		add_word(nrc_pkg::REQ_PIXEL, 6'd0, 16'd0, 8'd200, 8'd100, 8'd50, 0, '0);
		// Kernel wider than the image never yields a word.
		add_cfg(nrc_pkg::CFG_ROW_LENGTH, 11'd4);
		add_cfg(nrc_pkg::CFG_KERNEL_SIDE, 11'd7);
		add_word(nrc_pkg::REQ_PIXEL, 6'd0, 16'd0, 8'd1, 8'd2, 8'd3, 0, '0);
		add_word(nrc_pkg::REQ_PIXEL, 6'd0, 16'd0, 8'd4, 8'd5, 8'd6, 0, '0);
		add_word(nrc_pkg::REQ_COEF, 6'd1, 16'd3, 8'd0, 8'd0, 8'd0, 0, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (SETTLE) @(negedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) begin
				wait_quiet();
				write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
			end else begin
				send_word(stim_table[i].req, stim_table[i].cidx, stim_table[i].cval,
					stim_table[i].r, stim_table[i].g, stim_table[i].b,
					stim_table[i].typed, stim_table[i].want);
			end
		end

		mode = 0;
		while (items_sent < 1350) begin
			case (mode % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 75; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 75; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			mode++;
			// Close the running frame with a 1x1 geometry so a new kernel size
			// only ever sees rows written in its own frame.
			wait_quiet();
			write_reg(nrc_pkg::CFG_ROW_LENGTH, 11'd1);
			write_reg(nrc_pkg::CFG_ROW_COUNT, 11'd1);
			send_pixel();
			wait_quiet();
			k = $urandom_range(0, 7);
			write_reg(nrc_pkg::CFG_KERNEL_SIDE, nrc_pkg::CFG_W'(k));
			if ($urandom_range(0, 9) == 0) begin
				cols = ($urandom_range(0, 1)) ? 11'd1024 : 11'd2047;
				rows = nrc_pkg::CFG_W'($urandom_range(1, 2));
			end else if ($urandom_range(0, 9) == 0) begin
				cols = nrc_pkg::CFG_W'($urandom_range(1, 3));
				rows = ($urandom_range(0, 1)) ? 11'd1024 : 11'd0;
			end else begin
				cols = pick_extent(14);
				rows = pick_extent(10);
				if (cols > 16) cols = 11'd2047;
				if (rows > 16) rows = 11'd0;
			end
			write_reg(nrc_pkg::CFG_ROW_LENGTH, cols);
			write_reg(nrc_pkg::CFG_ROW_COUNT, rows);
			k = eff_k();
			for (int i = 0; i < k * k; i++) begin
				case ($urandom_range(0, 7))
					0: send_coef(6'(i), 16'd0);
					1: send_coef(6'(i), 16'hFFFF);
					2, 3: send_coef(6'(i), 16'($urandom_range(0, 15)));
					default: send_coef(6'(i), 16'($urandom));
				endcase
			end
			npix = $urandom_range(20, 90);
			for (int p = 0; p < npix; p++) begin
				if ($urandom_range(0, 19) == 0)
					send_coef(6'($urandom_range(0, 63)), 16'($urandom));
				else
					send_pixel();
				if (p == npix / 2 && $urandom_range(0, 3) == 0) begin
					// Shrinking the geometry mid-frame is safe for the line store.
					wait_quiet();
					if ($urandom_range(0, 1) && eff_cols() > 1)
						write_reg(nrc_pkg::CFG_ROW_LENGTH,
							nrc_pkg::CFG_W'($urandom_range(1, eff_cols() - 1)));
					else if (eff_rows() > 1)
						write_reg(nrc_pkg::CFG_ROW_COUNT,
							nrc_pkg::CFG_W'($urandom_range(1, eff_rows() - 1)));
				end
			end
		end

		wait_quiet();
		if (errors == 0)
			$display("normalized_rgb_convolution_unit test passed");
		else
			$display("normalized_rgb_convolution_unit test failed");
		$finish;
	end
endmodule

FILE: filelist.f
design/nrc_pkg.sv
design/nrc_div.sv
design/normalized_rgb_convolution_unit.sv
tb/normalized_rgb_convolution_unit_tb.sv
